@@ rtl/mtw_pkg.sv @@
`default_nettype none
package mtw_pkg;

   localparam int NumStates      = 64;
   localparam int NumSymbols     = 64;
   localparam int MaxTransitions = 1024;
   localparam int StW   = $clog2(NumStates);
   localparam int SymW  = $clog2(NumSymbols);
   localparam int NumW  = $clog2(MaxTransitions);
   localparam int TabW  = StW + SymW;
   localparam int TabD  = NumStates * NumSymbols;
   localparam int ScW   = StW + 1;
   localparam int TcW   = NumW + 1;
   localparam int OutW  = 10;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_BEGIN = 2'd1,
      OP_APPLY = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_UNDEF = 2'd1,
      ST_DUP  = 2'd2,
      ST_FULL = 2'd3
   } status_type;

   typedef struct packed {
      op_type           op;
      logic [StW-1:0]   fs;
      logic [SymW-1:0]  sym;
      logic [OutW-1:0]  osym;
      logic [StW-1:0]   ts;
   } cmd_type;

   typedef enum logic [2:0] {
      B_CLEAR, B_IDLE, B_LOOK, B_CLRTEST, B_UPD
   } back_state_type;

endpackage
`default_nettype wire

@@ rtl/mealy_table_walker_with_coverage.sv @@
`default_nettype none
// Table-driven Mealy machine with coverage counters. After reset the block sweeps its
// 4096-entry transition table before it takes the first transaction.
// Loads, applied symbols and unknown operations pass three steps in the back end (accept
// with table read, coverage read, update) and the result appears the cycle after; a
// begin-test transaction holds the back end while the per-test maps are cleared. The
// back end takes no new command until the pending result has been accepted.
// A two-entry queue in front lets requests arrive while the back end works.
module mealy_table_walker_with_coverage (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire  [1:0]  req_operation,
   input  wire  [5:0]  req_from_state,
   input  wire  [5:0]  req_in_symbol,
   input  wire  [9:0]  req_out_symbol,
   input  wire  [5:0]  req_to_state,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [9:0]  rsp_emitted_symbol,
   output logic [5:0]  rsp_next_state,
   output logic [9:0]  rsp_transition_number,
   output logic [6:0]  rsp_test_states_covered,
   output logic [10:0] rsp_test_transitions_covered,
   output logic [6:0]  rsp_suite_states_covered,
   output logic [10:0] rsp_suite_transitions_covered,
   output logic [6:0]  rsp_states_defined,
   output logic [10:0] rsp_transitions_defined
);
   import mtw_pkg::*;

   logic    cmd_valid, cmd_ready, clearing;
   cmd_type cmd;

   mtw_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_operation, .req_from_state,
      .req_in_symbol, .req_out_symbol, .req_to_state, .cmd_valid, .cmd, .cmd_ready
   );

   mtw_back u_back (
      .clock, .reset, .cmd_valid, .cmd, .cmd_ready, .rsp_valid, .rsp_ready,
      .rsp_status, .rsp_emitted_symbol, .rsp_next_state, .rsp_transition_number,
      .rsp_test_states_covered, .rsp_test_transitions_covered,
      .rsp_suite_states_covered, .rsp_suite_transitions_covered,
      .rsp_states_defined, .rsp_transitions_defined, .clearing
   );

`ifndef NO_ASSERTIONS
   a_no_cmd_clear: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !cmd_ready) else $error("command taken during clear");
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_suite_states_covered <= rsp_states_defined) else $error("coverage above defined");
   a_tt_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_test_transitions_covered <= rsp_suite_transitions_covered)
      else $error("test coverage above suite");
`endif
endmodule
`default_nettype wire

@@ rtl/mtw_front.sv @@
`default_nettype none
// Input stage and a two-entry command queue.
module mtw_front (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   input  wire  [1:0]            req_operation,
   input  wire  [5:0]            req_from_state,
   input  wire  [5:0]            req_in_symbol,
   input  wire  [9:0]            req_out_symbol,
   input  wire  [5:0]            req_to_state,
   output logic                  cmd_valid,
   output mtw_pkg::cmd_type      cmd,
   input  wire                   cmd_ready
);
   import mtw_pkg::*;

   cmd_type    q_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;
   cmd_type    c_in;

   always_comb begin
      c_in.op   = op_type'(req_operation);
      c_in.fs   = req_from_state;
      c_in.sym  = req_in_symbol;
      c_in.osym = req_out_symbol;
      c_in.ts   = req_to_state;
   end

   assign req_ready = (cnt_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign pop       = cmd_valid && cmd_ready;
   assign cmd       = q_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) q_ff[wp_ff] <= c_in;
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop)  rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end
endmodule
`default_nettype wire

@@ rtl/mtw_back.sv @@
`default_nettype none
// Table walk, loads and coverage bookkeeping.
module mtw_back (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   cmd_valid,
   input  mtw_pkg::cmd_type      cmd,
   output logic                  cmd_ready,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output logic [1:0]            rsp_status,
   output logic [9:0]            rsp_emitted_symbol,
   output logic [5:0]            rsp_next_state,
   output logic [9:0]            rsp_transition_number,
   output logic [6:0]            rsp_test_states_covered,
   output logic [10:0]           rsp_test_transitions_covered,
   output logic [6:0]            rsp_suite_states_covered,
   output logic [10:0]           rsp_suite_transitions_covered,
   output logic [6:0]            rsp_states_defined,
   output logic [10:0]           rsp_transitions_defined,
   output logic                  clearing
);
   import mtw_pkg::*;

   localparam int EntW = 1 + OutW + StW + NumW;

   // Table entry: valid, output, target, number.
   logic [EntW-1:0]  tab_mem [TabD];
   logic [EntW-1:0]  tab_rd_ff;
   logic             trt_mem [MaxTransitions];   // per-test transition map
   logic             trs_mem [MaxTransitions];   // suite-wide transition map
   logic             trt_rd_ff, trs_rd_ff;
   logic             known_mem [NumStates];
   logic             tseen_mem [NumStates];
   logic             sseen_mem [NumStates];
   logic             kn_a_ff, kn_b_ff, ts_a_ff, ts_b_ff, ss_a_ff, ss_b_ff;

   logic             init_v_ff;
   logic [StW-1:0]   init_ff, cur_ff;
   logic [ScW-1:0]   c_ts_ff, c_ss_ff, c_sd_ff;
   logic [TcW-1:0]   c_tt_ff, c_st_ff, c_td_ff;
   logic [TabW:0]    clr_ff;
   back_state_type   st_ff, st_in;
   cmd_type          cm_ff;

   logic             ov_ff;
   status_type       o_st_ff;
   logic [OutW-1:0]  o_em_ff;
   logic [StW-1:0]   o_nx_ff;
   logic [NumW-1:0]  o_nm_ff;

   logic [TabW-1:0]  look_addr;
   logic             e_v;
   logic [OutW-1:0]  e_o;
   logic [StW-1:0]   e_t;
   logic [NumW-1:0]  e_n;
   logic             take;
   logic             room;
   logic             ld_def;
   logic             ld_new;
   logic             ap_hit;
   status_type       upd_st;
   logic [OutW-1:0]  upd_em;
   logic [StW-1:0]   upd_nx;
   logic [NumW-1:0]  upd_nm;

   assign {e_v, e_o, e_t, e_n} = tab_rd_ff;
   assign clearing  = (st_ff == B_CLEAR);
   assign cmd_ready = (st_ff == B_IDLE) && !ov_ff;
   assign take      = cmd_valid && cmd_ready;
   assign look_addr = (cmd.op == OP_APPLY) ? {cur_ff, cmd.sym} : {cmd.fs, cmd.sym};
   assign room      = (c_td_ff < TcW'(MaxTransitions));
   // a duplicate or a stored load names both its states
   assign ld_def    = (cm_ff.op == OP_LOAD) && (e_v || room);
   assign ld_new    = (cm_ff.op == OP_LOAD) && !e_v && room;
   assign ap_hit    = (cm_ff.op == OP_APPLY) && e_v;

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         B_CLEAR:   if (clr_ff[TabW]) st_in = B_IDLE;
         B_IDLE:    if (take) begin
            priority if (cmd.op == OP_BEGIN) st_in = B_CLRTEST;
            else st_in = B_LOOK;
         end
         B_LOOK:    st_in = B_UPD;
         B_UPD:     st_in = B_IDLE;
         B_CLRTEST: if (clr_ff[NumW]) st_in = B_IDLE;
         default:   st_in = B_IDLE;
      endcase
   end

   always_comb begin
      upd_st = ST_OK;
      upd_em = '0;
      upd_nx = '0;
      upd_nm = '0;
      unique case (cm_ff.op)
         OP_LOAD: begin
            if (e_v) begin
               upd_st = ST_DUP; upd_em = e_o; upd_nx = e_t; upd_nm = e_n;
            end else if (!room) begin
               upd_st = ST_FULL;
            end else begin
               upd_em = cm_ff.osym; upd_nx = cm_ff.ts; upd_nm = c_td_ff[NumW-1:0];
            end
         end
         OP_APPLY: begin
            if (!e_v) upd_st = ST_UNDEF;
            else begin
               upd_em = e_o; upd_nx = e_t; upd_nm = e_n;
            end
         end
         default: ;
      endcase
   end

   // hold the entry read at the accepting edge until the update is done
   always_ff @(posedge clock) begin
      if (st_ff == B_IDLE) tab_rd_ff <= tab_mem[look_addr];
   end

   always_ff @(posedge clock) begin
      if (st_ff == B_CLEAR)
         tab_mem[clr_ff[TabW-1:0]] <= '0;
      else if (st_ff == B_LOOK && ld_new)
         tab_mem[{cm_ff.fs, cm_ff.sym}] <= {1'b1, cm_ff.osym, cm_ff.ts, c_td_ff[NumW-1:0]};
   end

   always_ff @(posedge clock) begin
      trt_rd_ff <= trt_mem[e_n];
      trs_rd_ff <= trs_mem[e_n];
   end

   always_ff @(posedge clock) begin
      if (st_ff == B_CLEAR || st_ff == B_CLRTEST)
         trt_mem[clr_ff[NumW-1:0]] <= 1'b0;
      else if (st_ff == B_UPD && ap_hit)
         trt_mem[e_n] <= 1'b1;
   end

   always_ff @(posedge clock) begin
      if (st_ff == B_CLEAR)
         trs_mem[clr_ff[NumW-1:0]] <= 1'b0;
      else if (st_ff == B_UPD && ap_hit)
         trs_mem[e_n] <= 1'b1;
   end

   // both state ids are read in the look cycle; mark the first then and the second in the update state
   always_ff @(posedge clock) begin
      kn_a_ff <= known_mem[cm_ff.fs];
      kn_b_ff <= known_mem[cm_ff.ts];
      ts_a_ff <= tseen_mem[cur_ff];
      ts_b_ff <= tseen_mem[e_t];
      ss_a_ff <= sseen_mem[cur_ff];
      ss_b_ff <= sseen_mem[e_t];
   end

   always_ff @(posedge clock) begin
      if (st_ff == B_CLEAR)
         known_mem[clr_ff[StW-1:0]] <= 1'b0;
      else if (st_ff == B_LOOK && ld_def)
         known_mem[cm_ff.fs] <= 1'b1;
      else if (st_ff == B_UPD && ld_def)
         known_mem[cm_ff.ts] <= 1'b1;
   end

   always_ff @(posedge clock) begin
      if (st_ff == B_CLEAR || st_ff == B_CLRTEST)
         tseen_mem[clr_ff[StW-1:0]] <= 1'b0;
      else if (st_ff == B_LOOK && ap_hit)
         tseen_mem[cur_ff] <= 1'b1;
      else if (st_ff == B_UPD && ap_hit)
         tseen_mem[e_t] <= 1'b1;
   end

   always_ff @(posedge clock) begin
      if (st_ff == B_CLEAR)
         sseen_mem[clr_ff[StW-1:0]] <= 1'b0;
      else if (st_ff == B_LOOK && ap_hit)
         sseen_mem[cur_ff] <= 1'b1;
      else if (st_ff == B_UPD && ap_hit)
         sseen_mem[e_t] <= 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= B_CLEAR; clr_ff <= '0; ov_ff <= 1'b0;
         init_v_ff <= 1'b0; init_ff <= '0; cur_ff <= '0;
         c_ts_ff <= '0; c_ss_ff <= '0; c_sd_ff <= '0;
         c_tt_ff <= '0; c_st_ff <= '0; c_td_ff <= '0;
      end else begin
         st_ff <= st_in;
         if (st_ff == B_UPD || (st_ff == B_CLRTEST && clr_ff[NumW])) ov_ff <= 1'b1;
         else if (rsp_valid && rsp_ready) ov_ff <= 1'b0;
         if (st_ff == B_CLEAR || st_ff == B_CLRTEST) clr_ff <= clr_ff + 1'b1;
         if (take) begin
            cm_ff  <= cmd;
            clr_ff <= '0;
            if (cmd.op == OP_BEGIN) begin
               cur_ff  <= init_v_ff ? init_ff : '0;
               c_ts_ff <= '0;
               c_tt_ff <= '0;
            end
         end
         if (st_ff == B_CLRTEST && clr_ff[NumW]) begin
            o_st_ff <= ST_OK; o_em_ff <= '0; o_nx_ff <= '0; o_nm_ff <= '0;
         end
         if (st_ff == B_UPD) begin
            o_st_ff <= upd_st; o_em_ff <= upd_em; o_nx_ff <= upd_nx; o_nm_ff <= upd_nm;
            if (ld_new) begin
               c_td_ff <= c_td_ff + 1'b1;
               if (!init_v_ff) begin
                  init_v_ff <= 1'b1;
                  init_ff   <= cm_ff.fs;
               end
            end
            if (ld_def)
               c_sd_ff <= c_sd_ff + ScW'(!kn_a_ff)
                        + ScW'(!kn_b_ff && cm_ff.ts != cm_ff.fs);
            if (ap_hit) begin
               cur_ff  <= e_t;
               c_ts_ff <= c_ts_ff + ScW'(!ts_a_ff) + ScW'(!ts_b_ff && e_t != cur_ff);
               c_ss_ff <= c_ss_ff + ScW'(!ss_a_ff) + ScW'(!ss_b_ff && e_t != cur_ff);
               c_tt_ff <= c_tt_ff + TcW'(!trt_rd_ff);
               c_st_ff <= c_st_ff + TcW'(!trs_rd_ff);
            end
         end
      end
   end

   assign rsp_valid                     = ov_ff;
   assign rsp_status                    = o_st_ff;
   assign rsp_emitted_symbol            = o_em_ff;
   assign rsp_next_state                = o_nx_ff;
   assign rsp_transition_number         = o_nm_ff;
   assign rsp_test_states_covered       = c_ts_ff;
   assign rsp_test_transitions_covered  = c_tt_ff;
   assign rsp_suite_states_covered      = c_ss_ff;
   assign rsp_suite_transitions_covered = c_st_ff;
   assign rsp_states_defined            = c_sd_ff;
   assign rsp_transitions_defined       = c_td_ff;
endmodule
`default_nettype wire
